// ===== hw/rtl/multichannel_envelope_generator_macros.svh =====
// Assertion macros for the envelope generator.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef MULTICHANNEL_ENVELOPE_GENERATOR_MACROS_SVH
`define MULTICHANNEL_ENVELOPE_GENERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS

`define MCEG_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("envelope generator check failed");

`define MCEG_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("envelope generator check failed");

`else

`define MCEG_ASSERT_NOW(label, ante, cons)

`define MCEG_ASSERT_NEXT(label, ante, cons)

`endif

`endif

// ===== hw/rtl/mceg_pkg.sv =====
`default_nettype none

package mceg_pkg;

    localparam int VOICES_DEFAULT = 28;
    localparam int GAIN_DEPTH = 1024;

    localparam logic [26:0] LEVEL_TOP = 27'h3FF0000;
    localparam logic [26:0] UNITY_STEP = 27'h4000000;

    typedef enum logic [1:0] {
        OP_KEY_ON,
        OP_KEY_OFF,
        OP_TICK,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        PH_ATTACK,
        PH_DECAY1,
        PH_DECAY2,
        PH_RELEASE
    } t_phase;

    typedef struct packed {
        t_op        op;
        logic [4:0] voice;
        logic [3:0] octave_code;
        logic [3:0] attack_nibble;
        logic [3:0] decay_nibble;
        logic [3:0] sustain_decay_nibble;
        logic [3:0] release_nibble;
        logic [3:0] decay_level_nibble;
        logic [3:0] key_scale_nibble;
    } t_item;

    typedef struct packed {
        logic [26:0] accum;
        t_phase      phase;
        logic        active;
        logic [23:0] rates;
        logic [3:0]  thr;
        logic        rel_instant;
    } t_voice_state;

    typedef logic [26:0] t_step_rom [64];
    typedef logic [11:0] t_gain_rom [GAIN_DEPTH];

    localparam longint unsigned ATK_NUM = (64'd1 << 26) * 64'd1000;
    localparam longint unsigned ATK_DEN = 64'd441;
    localparam longint unsigned DEC_NUM = (64'd1 << 26) * 64'd100000000;
    localparam longint unsigned DEC_DEN = 64'd441 * 64'd1432833;

    localparam t_step_rom ATTACK_STEP = '{
        27'd0, 27'd0, 27'd0, 27'd0,
        27'(ATK_NUM / (64'd622295 * ATK_DEN)), 27'(ATK_NUM / (64'd497837 * ATK_DEN)),
        27'(ATK_NUM / (64'd414866 * ATK_DEN)), 27'(ATK_NUM / (64'd355601 * ATK_DEN)),
        27'(ATK_NUM / (64'd311147 * ATK_DEN)), 27'(ATK_NUM / (64'd248921 * ATK_DEN)),
        27'(ATK_NUM / (64'd207433 * ATK_DEN)), 27'(ATK_NUM / (64'd177800 * ATK_DEN)),
        27'(ATK_NUM / (64'd155574 * ATK_DEN)), 27'(ATK_NUM / (64'd124463 * ATK_DEN)),
        27'(ATK_NUM / (64'd103719 * ATK_DEN)), 27'(ATK_NUM / (64'd88902 * ATK_DEN)),
        27'(ATK_NUM / (64'd77787 * ATK_DEN)), 27'(ATK_NUM / (64'd62231 * ATK_DEN)),
        27'(ATK_NUM / (64'd51859 * ATK_DEN)), 27'(ATK_NUM / (64'd44454 * ATK_DEN)),
        27'(ATK_NUM / (64'd38893 * ATK_DEN)), 27'(ATK_NUM / (64'd31116 * ATK_DEN)),
        27'(ATK_NUM / (64'd25932 * ATK_DEN)), 27'(ATK_NUM / (64'd22227 * ATK_DEN)),
        27'(ATK_NUM / (64'd19447 * ATK_DEN)), 27'(ATK_NUM / (64'd15560 * ATK_DEN)),
        27'(ATK_NUM / (64'd12966 * ATK_DEN)), 27'(ATK_NUM / (64'd11116 * ATK_DEN)),
        27'(ATK_NUM / (64'd9723 * ATK_DEN)), 27'(ATK_NUM / (64'd7782 * ATK_DEN)),
        27'(ATK_NUM / (64'd6485 * ATK_DEN)), 27'(ATK_NUM / (64'd5560 * ATK_DEN)),
        27'(ATK_NUM / (64'd4862 * ATK_DEN)), 27'(ATK_NUM / (64'd3891 * ATK_DEN)),
        27'(ATK_NUM / (64'd3243 * ATK_DEN)), 27'(ATK_NUM / (64'd2780 * ATK_DEN)),
        27'(ATK_NUM / (64'd2431 * ATK_DEN)), 27'(ATK_NUM / (64'd1946 * ATK_DEN)),
        27'(ATK_NUM / (64'd1624 * ATK_DEN)), 27'(ATK_NUM / (64'd1392 * ATK_DEN)),
        27'(ATK_NUM / (64'd1215 * ATK_DEN)), 27'(ATK_NUM / (64'd975 * ATK_DEN)),
        27'(ATK_NUM / (64'd812 * ATK_DEN)), 27'(ATK_NUM / (64'd698 * ATK_DEN)),
        27'(ATK_NUM / (64'd608 * ATK_DEN)), 27'(ATK_NUM / (64'd490 * ATK_DEN)),
        27'(ATK_NUM / (64'd408 * ATK_DEN)), 27'(ATK_NUM / (64'd349 * ATK_DEN)),
        27'(ATK_NUM / (64'd304 * ATK_DEN)), 27'(ATK_NUM / (64'd249 * ATK_DEN)),
        27'(ATK_NUM / (64'd213 * ATK_DEN)), 27'(ATK_NUM / (64'd190 * ATK_DEN)),
        27'(ATK_NUM / (64'd172 * ATK_DEN)), 27'(ATK_NUM / (64'd141 * ATK_DEN)),
        27'(ATK_NUM / (64'd118 * ATK_DEN)), 27'(ATK_NUM / (64'd104 * ATK_DEN)),
        27'(ATK_NUM / (64'd91 * ATK_DEN)), 27'(ATK_NUM / (64'd73 * ATK_DEN)),
        27'(ATK_NUM / (64'd59 * ATK_DEN)), 27'(ATK_NUM / (64'd50 * ATK_DEN)),
        27'(ATK_NUM / (64'd45 * ATK_DEN)), 27'(ATK_NUM / (64'd45 * ATK_DEN)),
        27'(ATK_NUM / (64'd45 * ATK_DEN)), UNITY_STEP
    };

    localparam t_step_rom DECAY_STEP = '{
        27'd0, 27'd0, 27'd0, 27'd0,
        27'(DEC_NUM / (64'd622295 * DEC_DEN)), 27'(DEC_NUM / (64'd497837 * DEC_DEN)),
        27'(DEC_NUM / (64'd414866 * DEC_DEN)), 27'(DEC_NUM / (64'd355601 * DEC_DEN)),
        27'(DEC_NUM / (64'd311147 * DEC_DEN)), 27'(DEC_NUM / (64'd248921 * DEC_DEN)),
        27'(DEC_NUM / (64'd207433 * DEC_DEN)), 27'(DEC_NUM / (64'd177800 * DEC_DEN)),
        27'(DEC_NUM / (64'd155574 * DEC_DEN)), 27'(DEC_NUM / (64'd124463 * DEC_DEN)),
        27'(DEC_NUM / (64'd103719 * DEC_DEN)), 27'(DEC_NUM / (64'd88902 * DEC_DEN)),
        27'(DEC_NUM / (64'd77787 * DEC_DEN)), 27'(DEC_NUM / (64'd62231 * DEC_DEN)),
        27'(DEC_NUM / (64'd51859 * DEC_DEN)), 27'(DEC_NUM / (64'd44454 * DEC_DEN)),
        27'(DEC_NUM / (64'd38893 * DEC_DEN)), 27'(DEC_NUM / (64'd31116 * DEC_DEN)),
        27'(DEC_NUM / (64'd25932 * DEC_DEN)), 27'(DEC_NUM / (64'd22227 * DEC_DEN)),
        27'(DEC_NUM / (64'd19447 * DEC_DEN)), 27'(DEC_NUM / (64'd15560 * DEC_DEN)),
        27'(DEC_NUM / (64'd12966 * DEC_DEN)), 27'(DEC_NUM / (64'd11116 * DEC_DEN)),
        27'(DEC_NUM / (64'd9723 * DEC_DEN)), 27'(DEC_NUM / (64'd7782 * DEC_DEN)),
        27'(DEC_NUM / (64'd6485 * DEC_DEN)), 27'(DEC_NUM / (64'd5560 * DEC_DEN)),
        27'(DEC_NUM / (64'd4862 * DEC_DEN)), 27'(DEC_NUM / (64'd3891 * DEC_DEN)),
        27'(DEC_NUM / (64'd3243 * DEC_DEN)), 27'(DEC_NUM / (64'd2780 * DEC_DEN)),
        27'(DEC_NUM / (64'd2431 * DEC_DEN)), 27'(DEC_NUM / (64'd1946 * DEC_DEN)),
        27'(DEC_NUM / (64'd1624 * DEC_DEN)), 27'(DEC_NUM / (64'd1392 * DEC_DEN)),
        27'(DEC_NUM / (64'd1215 * DEC_DEN)), 27'(DEC_NUM / (64'd975 * DEC_DEN)),
        27'(DEC_NUM / (64'd812 * DEC_DEN)), 27'(DEC_NUM / (64'd698 * DEC_DEN)),
        27'(DEC_NUM / (64'd608 * DEC_DEN)), 27'(DEC_NUM / (64'd490 * DEC_DEN)),
        27'(DEC_NUM / (64'd408 * DEC_DEN)), 27'(DEC_NUM / (64'd349 * DEC_DEN)),
        27'(DEC_NUM / (64'd304 * DEC_DEN)), 27'(DEC_NUM / (64'd249 * DEC_DEN)),
        27'(DEC_NUM / (64'd213 * DEC_DEN)), 27'(DEC_NUM / (64'd190 * DEC_DEN)),
        27'(DEC_NUM / (64'd172 * DEC_DEN)), 27'(DEC_NUM / (64'd141 * DEC_DEN)),
        27'(DEC_NUM / (64'd118 * DEC_DEN)), 27'(DEC_NUM / (64'd104 * DEC_DEN)),
        27'(DEC_NUM / (64'd91 * DEC_DEN)), 27'(DEC_NUM / (64'd73 * DEC_DEN)),
        27'(DEC_NUM / (64'd59 * DEC_DEN)), 27'(DEC_NUM / (64'd50 * DEC_DEN)),
        27'(DEC_NUM / (64'd45 * DEC_DEN)), 27'(DEC_NUM / (64'd45 * DEC_DEN)),
        27'(DEC_NUM / (64'd45 * DEC_DEN)), 27'(DEC_NUM / (64'd45 * DEC_DEN))
    };

    function automatic t_gain_rom build_gain();
        t_gain_rom   rom;
        logic [63:0] v;
        v = 64'd1 << 31;
        for (int i = GAIN_DEPTH - 1; i >= 0; i--) begin
            v = (v * 64'd2124429707 + (64'd1 << 30)) >> 31;
            rom[i] = 12'(v >> 19);
        end
        return rom;
    endfunction

    localparam t_gain_rom GAIN_TABLE = build_gain();

endpackage

`default_nettype wire

// ===== hw/rtl/mceg_state_mem.sv =====
`default_nettype none

module mceg_state_mem #(
    parameter int VOICES = mceg_pkg::VOICES_DEFAULT,
    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rd_en,
    input  wire logic [AW-1:0]          i_rd_addr,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire mceg_pkg::t_voice_state i_wr_data,
    output mceg_pkg::t_voice_state      o_rd_data
);

    mceg_pkg::t_voice_state r_mem [VOICES];
    mceg_pkg::t_voice_state r_rd_data;
    logic [VOICES-1:0]      r_valid;
    logic                   r_rd_valid;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // An entry never written reads as a silent voice at the start of attack.
    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_data.accum = '0;
            o_rd_data.phase = mceg_pkg::PH_ATTACK;
            o_rd_data.active = 1'b0;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mceg_env_calc.sv =====
`default_nettype none

module mceg_env_calc (
    input  wire mceg_pkg::t_item        i_item,
    input  wire logic                   i_in_range,
    input  wire mceg_pkg::t_voice_state i_cur,
    output mceg_pkg::t_voice_state      o_next,
    output logic                        o_write
);

    function automatic logic [5:0] step_index(logic [3:0] nib, logic signed [7:0] ksr);
        logic signed [7:0] p;
        p = signed'({2'b00, nib, 2'b00}) + ksr;
        if (nib == 4'd0) begin
            return 6'd0;
        end else if (nib == 4'd15) begin
            return 6'd63;
        end else if (p < 0) begin
            return 6'd0;
        end else if (p > 8'sd63) begin
            return 6'd63;
        end
        return p[5:0];
    endfunction

    logic signed [7:0] oct8;
    logic signed [7:0] ks8;
    logic signed [7:0] ksr;
    logic [5:0]        d_idx;
    logic [26:0]       a_step;
    logic [26:0]       d_step;
    logic [27:0]       sum;
    logic [26:0]       diff;

    always_comb begin
        oct8 = signed'({{4{i_item.octave_code[3]}}, i_item.octave_code});
        ks8 = signed'({4'b0000, i_item.key_scale_nibble});
        if (i_item.key_scale_nibble == 4'd15) begin
            ksr = '0;
        end else begin
            ksr = ((oct8 + ks8) <<< 1) + signed'({7'b0000000, i_item.octave_code[3]});
        end
    end

    always_comb begin
        unique case (i_cur.phase)
            mceg_pkg::PH_ATTACK:  d_idx = i_cur.rates[11:6];
            mceg_pkg::PH_DECAY1:  d_idx = i_cur.rates[11:6];
            mceg_pkg::PH_DECAY2:  d_idx = i_cur.rates[17:12];
            mceg_pkg::PH_RELEASE: d_idx = i_cur.rates[23:18];
        endcase
        a_step = mceg_pkg::ATTACK_STEP[i_cur.rates[5:0]];
        d_step = mceg_pkg::DECAY_STEP[d_idx];
        sum = {1'b0, i_cur.accum} + {1'b0, a_step};
        diff = (i_cur.accum > d_step) ? i_cur.accum - d_step : '0;
    end

    always_comb begin
        o_next = i_cur;
        o_write = 1'b0;
        unique case (i_item.op)
            mceg_pkg::OP_KEY_ON: begin
                o_next.rates = {step_index(i_item.release_nibble, ksr),
                                step_index(i_item.sustain_decay_nibble, ksr),
                                step_index(i_item.decay_nibble, ksr),
                                step_index(i_item.attack_nibble, ksr)};
                o_next.thr = 4'd15 - i_item.decay_level_nibble;
                o_next.rel_instant = (i_item.release_nibble == 4'd15);
                o_next.active = 1'b1;
                o_next.phase = mceg_pkg::PH_ATTACK;
                o_next.accum = '0;
                o_write = i_in_range;
            end
            mceg_pkg::OP_KEY_OFF: begin
                if (i_cur.active) begin
                    if (i_cur.rel_instant) begin
                        o_next.active = 1'b0;
                    end else begin
                        o_next.phase = mceg_pkg::PH_RELEASE;
                    end
                    o_write = i_in_range;
                end
            end
            mceg_pkg::OP_TICK: begin
                if (i_cur.active) begin
                    o_write = i_in_range;
                    unique case (i_cur.phase)
                        mceg_pkg::PH_ATTACK: begin
                            if (sum >= {1'b0, mceg_pkg::LEVEL_TOP}) begin
                                o_next.accum = mceg_pkg::LEVEL_TOP;
                                o_next.phase = (d_step >= mceg_pkg::UNITY_STEP)
                                    ? mceg_pkg::PH_DECAY2 : mceg_pkg::PH_DECAY1;
                            end else begin
                                o_next.accum = sum[26:0];
                            end
                        end
                        mceg_pkg::PH_DECAY1: begin
                            o_next.accum = diff;
                            if (diff[26:16] <= {1'b0, i_cur.thr, 6'b000000}) begin
                                o_next.phase = mceg_pkg::PH_DECAY2;
                            end
                        end
                        mceg_pkg::PH_DECAY2: begin
                            o_next.accum = diff;
                        end
                        mceg_pkg::PH_RELEASE: begin
                            o_next.accum = diff;
                            if (diff == '0) begin
                                o_next.active = 1'b0;
                            end
                        end
                    endcase
                end
            end
            mceg_pkg::OP_NONE: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/mceg_gain_rom.sv =====
`default_nettype none

module mceg_gain_rom (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rd_en,
    input  wire logic [$clog2(mceg_pkg::GAIN_DEPTH)-1:0] i_addr,
    output logic [11:0]                                o_data
);

    logic [11:0] r_data;

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_data <= mceg_pkg::GAIN_TABLE[i_addr];
        end
    end

    assign o_data = r_data;

endmodule

`default_nettype wire

// ===== hw/rtl/multichannel_envelope_generator.sv =====
// Envelope engine for a bank of voices with per-voice state in a memory.
// Input channel: i_valid with o_stall; an item carries an op (key on, key off,
// tick), a voice number and the rate, level and key scale nibbles used by key on.
// Output channel: o_valid with i_stall; every item gives exactly one result with
// the voice, its gain, level, phase and active flag after the item took effect.
// An item passes through the state memory read at the accepting edge, the update
// and write back together with the gain table lookup, and the load of the output
// register. No new item is taken until its result is in the output register;
// o_stall stays high from the accepting edge until that load.
// A result waiting in the output register does not block the next item; only
// when the next result is ready and the receiver still stalls does the block
// hold it and keep o_stall high.
// Reset clears the control state and marks every voice entry as silent, at the
// start of attack with a zero level; no clearing pass is needed.
// A voice number at or above the voice count changes nothing and reports zeros.
`default_nettype none
`include "multichannel_envelope_generator_macros.svh"

module multichannel_envelope_generator #(
    parameter int VOICES = mceg_pkg::VOICES_DEFAULT
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [1:0]  i_op,
    input  wire logic [4:0]  i_voice,
    input  wire logic [3:0]  i_octave_code,
    input  wire logic [3:0]  i_attack_nibble,
    input  wire logic [3:0]  i_decay_nibble,
    input  wire logic [3:0]  i_sustain_decay_nibble,
    input  wire logic [3:0]  i_release_nibble,
    input  wire logic [3:0]  i_decay_level_nibble,
    input  wire logic [3:0]  i_key_scale_nibble,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic [4:0]       o_out_voice,
    output logic [11:0]      o_gain,
    output logic [9:0]       o_level,
    output logic [1:0]       o_phase,
    output logic             o_active
);

    localparam int AW = (VOICES > 1) ? $clog2(VOICES) : 1;

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_GAIN
    } t_state;

    t_state                 r_state;
    mceg_pkg::t_item        r_item;
    logic                   r_in_range;
    logic                   r_res_active;
    logic [9:0]             r_res_level;
    logic [1:0]             r_res_phase;
    logic                   r_out_valid;
    logic [4:0]             r_out_voice;
    logic [11:0]            r_out_gain;
    logic [9:0]             r_out_level;
    logic [1:0]             r_out_phase;
    logic                   r_out_active;

    logic                   in_accept;
    logic                   in_range;
    logic                   calc_write;
    logic                   mem_we;
    logic                   out_silent;
    mceg_pkg::t_voice_state cur_state;
    mceg_pkg::t_voice_state n_voice;
    logic [11:0]            gain_data;

    assign in_accept = i_valid && !o_stall;
    assign in_range = (7'(i_voice) < 7'(VOICES));
    assign mem_we = (r_state == S_CALC) && calc_write;

    mceg_state_mem #(
        .VOICES (VOICES)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (in_accept && in_range),
        .i_rd_addr (AW'(i_voice)),
        .i_wr_en   (mem_we),
        .i_wr_addr (AW'(r_item.voice)),
        .i_wr_data (n_voice),
        .o_rd_data (cur_state)
    );

    mceg_env_calc u_env_calc (
        .i_item     (r_item),
        .i_in_range (r_in_range),
        .i_cur      (cur_state),
        .o_next     (n_voice),
        .o_write    (calc_write)
    );

    mceg_gain_rom u_gain_rom (
        .i_clk   (i_clk),
        .i_rd_en (r_state == S_CALC),
        .i_addr  (n_voice.accum[25:16]),
        .o_data  (gain_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_stall && (r_state != S_GAIN)) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_item <= '{op: mceg_pkg::t_op'(i_op),
                                    voice: i_voice,
                                    octave_code: i_octave_code,
                                    attack_nibble: i_attack_nibble,
                                    decay_nibble: i_decay_nibble,
                                    sustain_decay_nibble: i_sustain_decay_nibble,
                                    release_nibble: i_release_nibble,
                                    decay_level_nibble: i_decay_level_nibble,
                                    key_scale_nibble: i_key_scale_nibble};
                        r_in_range <= in_range;
                        r_state <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (r_in_range) begin
                        r_res_active <= n_voice.active;
                        r_res_level <= n_voice.accum[25:16];
                        r_res_phase <= n_voice.phase;
                    end else begin
                        r_res_active <= 1'b0;
                        r_res_level <= '0;
                        r_res_phase <= mceg_pkg::PH_ATTACK;
                    end
                    r_state <= S_GAIN;
                end
                S_GAIN: begin
                    if (!r_out_valid || !i_stall) begin
                        r_out_valid <= 1'b1;
                        r_out_voice <= r_item.voice;
                        r_out_gain <= r_res_active ? gain_data : '0;
                        r_out_level <= r_res_level;
                        r_out_phase <= r_res_phase;
                        r_out_active <= r_res_active;
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_out_valid;
    assign o_out_voice = r_out_voice;
    assign o_gain = r_out_gain;
    assign o_level = r_out_level;
    assign o_phase = r_out_phase;
    assign o_active = r_out_active;

    assign out_silent = !o_active && (o_level == 10'd0) && (o_phase == mceg_pkg::PH_ATTACK);

    `MCEG_ASSERT_NEXT(a_busy_after_accept, in_accept, o_stall)
    `MCEG_ASSERT_NOW(a_silent_gain, o_valid && !o_active, o_gain == 12'd0)
    `MCEG_ASSERT_NOW(a_out_of_range, o_valid && (7'(o_out_voice) >= 7'(VOICES)), out_silent)
    `MCEG_ASSERT_NEXT(a_write_once, mem_we, !mem_we)

endmodule

`default_nettype wire
